// ===== rtl/core/gcd_pkg.sv =====
// gcd_pkg.sv: shared widths, constants, the arctangent table and the angle bundle type
// of the great circle distance core. It has no dependencies; every other file imports it.
package gcd_pkg;

   // Number of CORDIC iterations in both the rotation and the vectoring pipelines.
   localparam int CordicSteps = 24;

   // Field and datapath widths.
   localparam int LatW  = 31;   // latitude input, degrees times 1e7
   localparam int LonW  = 32;   // longitude input, degrees times 1e7
   localparam int UW    = 34;   // angle in units of 5e-8 degree
   localparam int ZW    = 33;   // signed Q2.30 angle
   localparam int CW    = 33;   // signed Q2.30 sine and cosine
   localparam int RW    = 31;   // clamped haversine term and square roots
   localparam int DW    = 25;   // distance in metres
   localparam int QBits = 30;   // fraction bits of Q2.30

   // Angle reduction constants, in units of 5e-8 degree.
   localparam logic [32:0] TurnUnits   = 33'd7200000000;
   localparam logic [31:0] HalfTurn    = 32'd3600000000;
   localparam logic [30:0] QuarterTurn = 31'd1800000000;

   // Pi times 2^31, split into a high and a low part for two narrow products.
   localparam logic [16:0] PiHi = 17'h1921F;
   localparam logic [15:0] PiLo = 16'hB544;

   localparam logic [29:0]   CordicGain = 30'd652032874;
   localparam logic [RW-1:0] QOne       = 31'h40000000;
   localparam logic [23:0]   EarthDiamM = 24'd12742000;
   localparam logic [DW-1:0] DistMax    = 25'd20015087;

   // Arctangent of 2^-i in Q2.30, rounded to nearest.
   localparam logic [29:0] AtanTable [0:31] = '{
      30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
      30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
      30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
      30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
      30'd1024,      30'd512,       30'd256,       30'd128,       30'd64,
      30'd32,        30'd16,        30'd8,         30'd4,         30'd2,
      30'd1,         30'd0
   };

   // Reduced angle handed from the converter to the rotation CORDIC.
   typedef struct packed {
      logic          valid;
      logic          neg;     // sine and cosine must be negated
      logic [ZW-1:0] z;       // signed Q2.30 radians
   } angle_type;

endpackage

// ===== rtl/core/great_circle_distance_core.sv =====
// great_circle_distance_core.sv: top level of the haversine distance pipeline.
// Depends on gcd_pkg, gcd_angle, gcd_sincos, gcd_isqrt and gcd_vector.
//
//   Channel   Ports                                   Transfer
//   input     start, busy, req_station_lat/lon,       start high and busy low at a rising edge
//             req_point_lat/lon
//   result    rsp_valid, rsp_distance_m               rsp_valid high for one cycle
//
// One point pair is taken every clock cycle; busy stays low.
// Each pair passes through the nine angle conversion stages, the rotation CORDIC
// pipeline, the product and clamp stages, the 31-stage square root and the vectoring
// CORDIC pipeline.
// Reset clears only the valid bits; no result is lost since the receiver cannot stall.
module great_circle_distance_core import gcd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic signed [LatW-1:0] req_station_lat,
   input  logic signed [LonW-1:0] req_station_lon,
   input  logic signed [LatW-1:0] req_point_lat,
   input  logic signed [LonW-1:0] req_point_lon,
   output logic                   rsp_valid,
   output logic [DW-1:0]          rsp_distance_m
);

   localparam int HW = CW + 1;

   assign busy = 1'b0;

   // Input stage: half differences and full latitudes in units of 5e-8 degree.
   logic signed [UW-1:0] u_dlat_ff, u_dlon_ff, u_lat1_ff, u_lat2_ff;
   logic                 v0_ff;

   always_ff @(posedge clock) begin
      u_dlat_ff <= UW'(req_station_lat) - UW'(req_point_lat);
      u_dlon_ff <= UW'(req_station_lon) - UW'(req_point_lon);
      u_lat1_ff <= UW'(req_station_lat) + UW'(req_station_lat);
      u_lat2_ff <= UW'(req_point_lat) + UW'(req_point_lat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start & ~busy;
      end
   end

   // Four angle lanes running in lockstep.
   angle_type ang_dlat, ang_dlon, ang_lat1, ang_lat2;

   gcd_angle u_ang_dlat (.clock, .reset, .in_valid(v0_ff), .in_u(u_dlat_ff), .out_ang(ang_dlat));
   gcd_angle u_ang_dlon (.clock, .reset, .in_valid(v0_ff), .in_u(u_dlon_ff), .out_ang(ang_dlon));
   gcd_angle u_ang_lat1 (.clock, .reset, .in_valid(v0_ff), .in_u(u_lat1_ff), .out_ang(ang_lat1));
   gcd_angle u_ang_lat2 (.clock, .reset, .in_valid(v0_ff), .in_u(u_lat2_ff), .out_ang(ang_lat2));

   logic                 sc_valid;
   logic signed [CW-1:0] s_dlat, s_dlon, c_lat1, c_lat2;

   gcd_sincos u_sc_dlat (
      .clock, .reset, .in_ang(ang_dlat),
      .out_valid(sc_valid), .out_sin(s_dlat), .out_cos()
   );
   gcd_sincos u_sc_dlon (
      .clock, .reset, .in_ang(ang_dlon),
      .out_valid(), .out_sin(s_dlon), .out_cos()
   );
   gcd_sincos u_sc_lat1 (
      .clock, .reset, .in_ang(ang_lat1),
      .out_valid(), .out_sin(), .out_cos(c_lat1)
   );
   gcd_sincos u_sc_lat2 (
      .clock, .reset, .in_ang(ang_lat2),
      .out_valid(), .out_sin(), .out_cos(c_lat2)
   );

   // Product stage 1: squares of the two sines.
   logic signed [2*CW-1:0] sq_a, sq_b;
   logic signed [CW-1:0]   t1_ff, t2_ff, c1_p1_ff, c2_p1_ff;
   logic                   v1_ff;

   assign sq_a = s_dlat * s_dlat;
   assign sq_b = s_dlon * s_dlon;

   always_ff @(posedge clock) begin
      t1_ff    <= sq_a[QBits+CW-1:QBits];
      t2_ff    <= sq_b[QBits+CW-1:QBits];
      c1_p1_ff <= c_lat1;
      c2_p1_ff <= c_lat2;
   end

   // Product stage 2: longitude term times the first cosine.
   logic signed [2*CW-1:0] pr1;
   logic signed [CW-1:0]   p_ff, t1_p2_ff, c2_p2_ff;
   logic                   v2_ff;

   assign pr1 = t2_ff * c1_p1_ff;

   always_ff @(posedge clock) begin
      p_ff     <= pr1[QBits+CW-1:QBits];
      t1_p2_ff <= t1_ff;
      c2_p2_ff <= c2_p1_ff;
   end

   // Product stage 3: times the second cosine, then the haversine sum.
   logic signed [2*CW-1:0] pr2;
   logic signed [HW-1:0]   h_in, h_ff;
   logic                   v3_ff;

   assign pr2  = p_ff * c2_p2_ff;
   assign h_in = HW'(t1_p2_ff) + HW'($signed(pr2[QBits+CW-1:QBits]));

   always_ff @(posedge clock) begin
      h_ff <= h_in;
   end

   // Clamp stage: h into [0, 1] and its complement.
   logic [RW-1:0] hc_in, hc_ff, hmc_ff;
   logic          v4_ff;

   always_comb begin
      if (h_ff[HW-1]) begin
         hc_in = '0;
      end else if (h_ff > HW'(QOne)) begin
         hc_in = QOne;
      end else begin
         hc_in = h_ff[RW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      hc_ff  <= hc_in;
      hmc_ff <= QOne - hc_in;
   end

   // Valid bits of the product and clamp stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= sc_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Square roots of h and 1 - h, side by side.
   logic          rt_valid;
   logic [RW-1:0] root_x, root_y;

   gcd_isqrt u_sqrt_y (
      .clock, .reset, .in_valid(v4_ff), .in_value(hc_ff),
      .out_valid(rt_valid), .out_root(root_y)
   );
   gcd_isqrt u_sqrt_x (
      .clock, .reset, .in_valid(v4_ff), .in_value(hmc_ff),
      .out_valid(), .out_root(root_x)
   );

   // Central angle and scaling to metres.
   gcd_vector u_vector (
      .clock, .reset, .in_valid(rt_valid), .in_x(root_x), .in_y(root_y),
      .out_valid(rsp_valid), .out_distance(rsp_distance_m)
   );

endmodule

// ===== rtl/core/gcd_angle.sv =====
// gcd_angle.sv: reduces an angle to [-90, 90] degrees and converts it to Q2.30 radians.
// Divides by the turn with a reciprocal multiplication and a compare-and-adjust step;
// depends on gcd_pkg.
module gcd_angle import gcd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic signed [UW-1:0] in_u,
   output angle_type            out_ang
);

   localparam int EW   = UW + 1;
   localparam int QW   = 31;       // quotient bits
   localparam int NW   = 64;       // dividend bits
   localparam int HiW  = 48;
   localparam int LoW  = 47;
   localparam int MW   = NW - 11;  // dividend with the factor 2^11 of the turn removed
   localparam int PhW  = MW;       // high partial product bits, 21 by 32
   localparam int SumW = MW + 32;  // full reciprocal product bits
   localparam int LW   = 24;       // low bits kept for the remainder check

   localparam logic signed [EW-1:0] TurnS  = EW'(TurnUnits);
   localparam logic signed [EW-1:0] HalfS  = EW'(HalfTurn);
   localparam logic signed [EW-1:0] QuartS = EW'(QuarterTurn);

   // The turn is 2^11 times 3515625; the odd factor is divided by its reciprocal.
   localparam logic [LW-1:0] DivOdd = 24'd3515625;
   localparam logic [31:0]   Recip  = 32'd2562047788;   // floor(2^53 / 3515625)

   // Stage 1: wrap into [-half turn, half turn).
   logic signed [EW-1:0] ue, r1_in;
   logic signed [32:0]   r1_ff;
   logic                 v1_ff;

   always_comb begin
      ue = EW'(in_u);
      if (ue < -HalfS) begin
         r1_in = ue + TurnS;
      end else if (ue >= HalfS) begin
         r1_in = ue - TurnS;
      end else begin
         r1_in = ue;
      end
   end

   always_ff @(posedge clock) begin
      r1_ff <= r1_in[32:0];
   end

   // Stage 2: fold into [-quarter turn, quarter turn] and split sign and magnitude.
   logic signed [EW-1:0] re, rf;
   logic                 neg2_in;
   logic [30:0]          mag_in, mag_ff;
   logic                 neg2_ff, sgn2_ff, v2_ff;

   always_comb begin
      re      = EW'(r1_ff);
      neg2_in = 1'b0;
      if (re > QuartS) begin
         rf      = re - HalfS;
         neg2_in = 1'b1;
      end else if (re < -QuartS) begin
         rf      = re + HalfS;
         neg2_in = 1'b1;
      end else begin
         rf = re;
      end
      mag_in = rf[EW-1] ? 31'(-rf) : rf[30:0];
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg2_ff <= neg2_in;
      sgn2_ff <= rf[EW-1];
   end

   // Stage 3: magnitude times pi, as two partial products.
   logic [HiW-1:0] pp_hi_in, pp_hi_ff;
   logic [LoW-1:0] pp_lo_in, pp_lo_ff;
   logic           neg3_ff, sgn3_ff, v3_ff;

   assign pp_hi_in = HiW'(mag_ff) * HiW'(PiHi);
   assign pp_lo_in = LoW'(mag_ff) * LoW'(PiLo);

   always_ff @(posedge clock) begin
      pp_hi_ff <= pp_hi_in;
      pp_lo_ff <= pp_lo_in;
      neg3_ff  <= neg2_ff;
      sgn3_ff  <= sgn2_ff;
   end

   // Stage 4: sum the partial products with the rounding offset and drop the factor 2^11.
   logic [NW-1:0] n_in;
   logic [MW-1:0] nq_ff;
   logic          neg4_ff, sgn4_ff, v4_ff;

   assign n_in = (NW'(pp_hi_ff) << 16) + NW'(pp_lo_ff) + NW'(HalfTurn);

   always_ff @(posedge clock) begin
      nq_ff   <= n_in[NW-1:11];
      neg4_ff <= neg3_ff;
      sgn4_ff <= sgn3_ff;
   end

   // Stage 5: dividend times the reciprocal, as two partial products.
   logic [PhW-1:0] ph_in, ph_ff;
   logic [63:0]    pl_in, pl_ff;
   logic [LW-1:0]  nlo5_ff;
   logic           neg5_ff, sgn5_ff, v5_ff;

   assign ph_in = PhW'(nq_ff[MW-1:32]) * PhW'(Recip);
   assign pl_in = 64'(nq_ff[31:0]) * 64'(Recip);

   always_ff @(posedge clock) begin
      ph_ff   <= ph_in;
      pl_ff   <= pl_in;
      nlo5_ff <= nq_ff[LW-1:0];
      neg5_ff <= neg4_ff;
      sgn5_ff <= sgn4_ff;
   end

   // Stage 6: quotient estimate, equal to the quotient or one below it.
   logic [SumW-1:0] quot_sum;
   logic [QW-1:0]   qe6_ff;
   logic [LW-1:0]   nlo6_ff;
   logic            neg6_ff, sgn6_ff, v6_ff;

   assign quot_sum = (SumW'(ph_ff) << 32) + SumW'(pl_ff);

   always_ff @(posedge clock) begin
      qe6_ff  <= quot_sum[MW+QW-1:MW];
      nlo6_ff <= nlo5_ff;
      neg6_ff <= neg5_ff;
      sgn6_ff <= sgn5_ff;
   end

   // Stage 7: low bits of the estimate times the divisor.
   logic [LW-1:0] m_in, m_ff, nlo7_ff;
   logic [QW-1:0] qe7_ff;
   logic          neg7_ff, sgn7_ff, v7_ff;

   assign m_in = qe6_ff[LW-1:0] * DivOdd;

   always_ff @(posedge clock) begin
      m_ff    <= m_in;
      nlo7_ff <= nlo6_ff;
      qe7_ff  <= qe6_ff;
      neg7_ff <= neg6_ff;
      sgn7_ff <= sgn6_ff;
   end

   // Stage 8: the remainder is below twice the divisor, so one compare fixes the estimate.
   logic [LW-1:0] rem_lo;
   logic [QW-1:0] q_in, q_ff;
   logic          neg8_ff, sgn8_ff, v8_ff;

   assign rem_lo = nlo7_ff - m_ff;
   assign q_in   = qe7_ff + QW'(rem_lo >= DivOdd);

   always_ff @(posedge clock) begin
      q_ff    <= q_in;
      neg8_ff <= neg7_ff;
      sgn8_ff <= sgn7_ff;
   end

   // Output stage: put the sign back.
   logic [ZW-1:0] z_in, z_ff;
   logic          zneg_ff, zv_ff;

   assign z_in = sgn8_ff ? (ZW'(0) - ZW'(q_ff)) : ZW'(q_ff);

   always_ff @(posedge clock) begin
      z_ff    <= z_in;
      zneg_ff <= neg8_ff;
   end

   // Valid bits of all stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         zv_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
         zv_ff <= v8_ff;
      end
   end

   assign out_ang.valid = zv_ff;
   assign out_ang.neg   = zneg_ff;
   assign out_ang.z     = z_ff;

endmodule

// ===== rtl/core/gcd_sincos.sv =====
// gcd_sincos.sv: pipelined rotation CORDIC giving Q2.30 sine and cosine of a reduced angle.
// One iteration per stage; depends on gcd_pkg.
module gcd_sincos import gcd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  angle_type            in_ang,
   output logic                 out_valid,
   output logic signed [CW-1:0] out_sin,
   output logic signed [CW-1:0] out_cos
);

   localparam int Last = CordicSteps - 1;

   logic signed [CW-1:0] x_ff [0:Last];
   logic signed [CW-1:0] y_ff [0:Last];
   logic signed [ZW-1:0] z_ff [0:Last];
   logic                 neg_ff [0:Last];
   logic                 v_ff [0:Last];

   for (genvar j = 0; j < CordicSteps; j++) begin : g_iter
      localparam logic signed [ZW-1:0] AtanZ = ZW'(AtanTable[j]);
      logic signed [CW-1:0] xp, yp;
      logic signed [ZW-1:0] zp;
      logic                 np, vp;

      if (j == 0) begin : g_first
         assign xp = CW'(CordicGain);
         assign yp = '0;
         assign zp = $signed(in_ang.z);
         assign np = in_ang.neg;
         assign vp = in_ang.valid;
      end else begin : g_next
         assign xp = x_ff[j-1];
         assign yp = y_ff[j-1];
         assign zp = z_ff[j-1];
         assign np = neg_ff[j-1];
         assign vp = v_ff[j-1];
      end

      // Rotate toward zero residual angle.
      always_ff @(posedge clock) begin
         if (zp >= 0) begin
            x_ff[j] <= xp - (yp >>> j);
            y_ff[j] <= yp + (xp >>> j);
            z_ff[j] <= zp - AtanZ;
         end else begin
            x_ff[j] <= xp + (yp >>> j);
            y_ff[j] <= yp - (xp >>> j);
            z_ff[j] <= zp + AtanZ;
         end
         neg_ff[j] <= np;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else begin
            v_ff[j] <= vp;
         end
      end
   end

   // Output stage: undo the half-turn fold.
   logic signed [CW-1:0] sin_ff, cos_ff;
   logic                 ov_ff;

   always_ff @(posedge clock) begin
      sin_ff <= neg_ff[Last] ? -y_ff[Last] : y_ff[Last];
      cos_ff <= neg_ff[Last] ? -x_ff[Last] : x_ff[Last];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= v_ff[Last];
      end
   end

   assign out_valid = ov_ff;
   assign out_sin   = sin_ff;
   assign out_cos   = cos_ff;

endmodule

// ===== rtl/core/gcd_isqrt.sv =====
// gcd_isqrt.sv: pipelined truncating square root of a Q2.30 value, one root bit per stage.
// Depends on gcd_pkg.
module gcd_isqrt import gcd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [RW-1:0] in_value,
   output logic          out_valid,
   output logic [RW-1:0] out_root
);

   localparam int NW = RW + QBits;   // radicand bits
   localparam int SW = NW + 1;       // trial subtrahend bits

   logic [NW-1:0] rem_ff [0:RW-1];
   logic [RW-1:0] res_ff [0:RW-1];
   logic          v_ff   [0:RW-1];

   for (genvar j = 0; j < RW; j++) begin : g_bit
      localparam int K = RW - 1 - j;
      logic [NW-1:0] remp;
      logic [RW-1:0] resp;
      logic          vp;
      logic [SW-1:0] d;
      logic          ge;

      if (j == 0) begin : g_first
         assign remp = {in_value, {QBits{1'b0}}};
         assign resp = '0;
         assign vp   = in_valid;
      end else begin : g_next
         assign remp = rem_ff[j-1];
         assign resp = res_ff[j-1];
         assign vp   = v_ff[j-1];
      end

      // Try setting root bit K: (res + 2^K)^2 - res^2 against the remainder.
      assign d  = (SW'(resp) << (K + 1)) | (SW'(1) << (2 * K));
      assign ge = {1'b0, remp} >= d;

      always_ff @(posedge clock) begin
         rem_ff[j] <= ge ? NW'({1'b0, remp} - d) : remp;
         res_ff[j] <= ge ? (resp | (RW'(1) << K)) : resp;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else begin
            v_ff[j] <= vp;
         end
      end
   end

   assign out_valid = v_ff[RW-1];
   assign out_root  = res_ff[RW-1];

endmodule

// ===== rtl/core/gcd_vector.sv =====
// gcd_vector.sv: pipelined vectoring CORDIC for the central angle, then scaling to metres.
// Depends on gcd_pkg.
module gcd_vector import gcd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [RW-1:0] in_x,
   input  logic [RW-1:0] in_y,
   output logic          out_valid,
   output logic [DW-1:0] out_distance
);

   localparam int VW   = 34;
   localparam int Last = CordicSteps - 1;
   localparam int PW   = RW + 24;     // angle times diameter

   logic signed [VW-1:0] x_ff [0:Last];
   logic signed [VW-1:0] y_ff [0:Last];
   logic signed [VW-1:0] z_ff [0:Last];
   logic                 v_ff [0:Last];

   for (genvar j = 0; j < CordicSteps; j++) begin : g_iter
      localparam logic signed [VW-1:0] AtanZ = VW'(AtanTable[j]);
      logic signed [VW-1:0] xp, yp, zp;
      logic                 vp;

      if (j == 0) begin : g_first
         assign xp = VW'(in_x);
         assign yp = VW'(in_y);
         assign zp = '0;
         assign vp = in_valid;
      end else begin : g_next
         assign xp = x_ff[j-1];
         assign yp = y_ff[j-1];
         assign zp = z_ff[j-1];
         assign vp = v_ff[j-1];
      end

      // Rotate the vector onto the x axis and sum the angle.
      always_ff @(posedge clock) begin
         if (yp >= 0) begin
            x_ff[j] <= xp + (yp >>> j);
            y_ff[j] <= yp - (xp >>> j);
            z_ff[j] <= zp + AtanZ;
         end else begin
            x_ff[j] <= xp - (yp >>> j);
            y_ff[j] <= yp + (xp >>> j);
            z_ff[j] <= zp - AtanZ;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else begin
            v_ff[j] <= vp;
         end
      end
   end

   // Clamp a negative angle to zero and scale by the earth diameter.
   logic [RW-1:0] zc;
   logic [PW-1:0] prod_in, prod_ff;
   logic          pv_ff;

   assign zc      = z_ff[Last][VW-1] ? '0 : z_ff[Last][RW-1:0];
   assign prod_in = PW'(zc) * PW'(EarthDiamM);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Drop the fraction and saturate at half the circumference.
   logic [DW-1:0] dist_raw;
   logic [DW-1:0] dist_ff;
   logic          ov_ff;

   assign dist_raw = prod_ff[PW-1:QBits];

   always_ff @(posedge clock) begin
      dist_ff <= (dist_raw > DistMax) ? DistMax : dist_raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         pv_ff <= v_ff[Last];
         ov_ff <= pv_ff;
      end
   end

   assign out_valid    = ov_ff;
   assign out_distance = dist_ff;

endmodule

// ===== tb/sv/tb_great_circle_distance_core.sv =====
// tb_great_circle_distance_core.sv: self-checking testbench for the haversine distance core.
// Depends on gcd_pkg and great_circle_distance_core; predicts every distance in fixed point.
`timescale 1ns / 1ps

module tb_great_circle_distance_core;
   import gcd_pkg::*;

   localparam longint TurnU    = 64'd7200000000;
   localparam longint HalfU    = 64'd3600000000;
   localparam longint QuarterU = 64'd1800000000;
   localparam longint unsigned PiQ31 = 64'h1921FB544;
   localparam longint QOneL    = 64'd1 << 30;
   localparam int     NumDirected = 18;

   typedef struct {
      longint lat1;
      longint lon1;
      longint lat2;
      longint lon2;
   } pair_t;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic signed [LatW-1:0] req_station_lat;
   logic signed [LonW-1:0] req_station_lon;
   logic signed [LatW-1:0] req_point_lat;
   logic signed [LonW-1:0] req_point_lon;
   logic                   rsp_valid;
   logic [DW-1:0]          rsp_distance_m;

   logic [DW-1:0] pending_distances [$];
   int            error_count;

   // Poles, date line, antipodes, tiny steps and coordinates far out of range.
   pair_t directed_pairs [NumDirected] = '{
      '{0, 0, 0, 0},
      '{900000000, 0, -900000000, 0},
      '{0, 0, 0, 1800000000},
      '{0, -1800000000, 0, 1800000000},
      '{0, 0, 0, -1800000000},
      '{900000000, 1800000000, 900000000, -1800000000},
      '{-900000000, 0, 900000000, 1800000000},
      '{0, 0, 0, 900000000},
      '{0, 0, 1, 1},
      '{454000000, 93000000, 454000010, 93000000},
      '{1073741823, 2147483647, -1073741824, -2147483648},
      '{-1073741824, -2147483648, -1073741824, 2147483647},
      '{1073741823, 0, 0, 0},
      '{450000000, 0, -450000000, 1800000000},
      '{515000000, -1200000, 407000000, -740000000},
      '{-338000000, 1512000000, 515000000, -1200000},
      '{899999999, 1799999999, -899999999, -1799999999},
      '{0, 2147483647, 0, -2147483648}
   };

   great_circle_distance_core dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_station_lat (req_station_lat),
      .req_station_lon (req_station_lon),
      .req_point_lat   (req_point_lat),
      .req_point_lon   (req_point_lon),
      .rsp_valid       (rsp_valid),
      .rsp_distance_m  (rsp_distance_m)
   );

   // Free-running clock with a 10 ns period.
   always #5 clock = ~clock;

   // Truncating integer square root.
   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned root;
      longint unsigned b;
      root = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= root + b) begin
            n = n - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   // Sine and cosine in Q2.30 of an angle given in units of 5e-8 degree.
   function automatic void angle_sin_cos(input longint u, output longint s, output longint c);
      longint          r;
      longint          z;
      longint          x;
      longint          y;
      longint          dx;
      longint          dy;
      longint unsigned mag;
      bit              flip;
      r = u % TurnU;
      flip = 0;
      if (r < 0) r = r + TurnU;
      if (r >= HalfU) r = r - TurnU;
      if (r > QuarterU) begin
         r = r - HalfU;
         flip = 1;
      end else if (r < -QuarterU) begin
         r = r + HalfU;
         flip = 1;
      end
      mag = (r < 0) ? -r : r;
      mag = (mag * PiQ31 + HalfU) / TurnU;
      z = (r < 0) ? -longint'(mag) : longint'(mag);
      x = longint'(CordicGain);
      y = 0;
      for (int i = 0; i < CordicSteps && i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - longint'(AtanTable[i]);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + longint'(AtanTable[i]);
         end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endfunction

   // Haversine distance in metres, truncated and saturated.
   function automatic logic [DW-1:0] haversine_metres(input longint lat1, input longint lon1,
                                                      input longint lat2, input longint lon2);
      longint          s_lat;
      longint          c_lat;
      longint          s_lon;
      longint          c_lon;
      longint          dummy;
      longint          cos1;
      longint          cos2;
      longint          h;
      longint          x;
      longint          y;
      longint          z;
      longint          dx;
      longint          dy;
      longint unsigned d;
      angle_sin_cos(lat1 - lat2, s_lat, c_lat);
      angle_sin_cos(lon1 - lon2, s_lon, c_lon);
      angle_sin_cos(2 * lat1, dummy, cos1);
      angle_sin_cos(2 * lat2, dummy, cos2);
      h = ((s_lat * s_lat) >>> 30) + (((((s_lon * s_lon) >>> 30) * cos1) >>> 30) * cos2 >>> 30);
      if (h < 0) h = 0;
      if (h > QOneL) h = QOneL;
      // Central angle from a vectoring rotation of (sqrt(1-h), sqrt(h)).
      x = longint'(int_sqrt(longint'(QOneL - h) << 30));
      y = longint'(int_sqrt(longint'(h) << 30));
      z = 0;
      for (int i = 0; i < CordicSteps && i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            z = z + longint'(AtanTable[i]);
         end else begin
            x = x - dx;
            y = y + dy;
            z = z - longint'(AtanTable[i]);
         end
      end
      if (z < 0) z = 0;
      d = (longint'(z) * longint'(EarthDiamM)) >> 30;
      if (d > longint'(DistMax)) d = longint'(DistMax);
      return d[DW-1:0];
   endfunction

   task automatic report_mismatch(input string what, input longint expd, input longint got);
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, expd, got);
      error_count++;
   endtask

   // Random latitude: mostly in range, some at the edges, some any bit pattern.
   function automatic longint random_lat();
      int pick;
      pick = $urandom_range(99);
      if (pick < 75) return longint'($urandom_range(1800000000, 0)) - 900000000;
      if (pick < 85) return ($urandom_range(1)) ? 900000000 : -900000000;
      return longint'($signed(31'($urandom)));
   endfunction

   function automatic longint random_lon();
      int pick;
      pick = $urandom_range(99);
      if (pick < 75) return longint'($urandom_range(32'd3600000000, 0)) - 1800000000;
      if (pick < 85) return ($urandom_range(1)) ? 1800000000 : -1800000000;
      return longint'($signed(32'($urandom)));
   endfunction

   // Most often no gap at all, else mostly a short one, now and then a long one.
   function automatic int random_gap();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 4);
   endfunction

   // Drive one point pair, wait for its transfer and record the expected distance.
   task automatic send_pair(input pair_t p);
      int gap;
      start <= 1'b1;
      req_station_lat <= p.lat1[LatW-1:0];
      req_station_lon <= p.lon1[LonW-1:0];
      req_point_lat <= p.lat2[LatW-1:0];
      req_point_lon <= p.lon2[LonW-1:0];
      do @(posedge clock); while (busy);
      pending_distances.push_back(haversine_metres(longint'(req_station_lat),
         longint'(req_station_lon), longint'(req_point_lat), longint'(req_point_lon)));
      gap = random_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_distances();
      start <= 1'b0;
      while (pending_distances.size() != 0) @(posedge clock);
   endtask

   // Result checker: every strobed distance must match the oldest prediction.
   always @(posedge clock) begin
      if (rsp_valid === 1'b1) begin
         if (pending_distances.size() == 0) begin
            report_mismatch("unexpected distance", -1, rsp_distance_m);
         end else if (rsp_distance_m !== pending_distances[0]) begin
            report_mismatch("distance_m", pending_distances.pop_front(), rsp_distance_m);
         end else begin
            void'(pending_distances.pop_front());
         end
      end
   end

   // Stimulus: directed pairs, then random pairs with varying locality.
   initial begin
      pair_t p;
      int    mode;
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_station_lat = '0;
      req_station_lon = '0;
      req_point_lat = '0;
      req_point_lon = '0;
      error_count = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_pairs[i]) send_pair(directed_pairs[i]);

      for (int n = 0; n < 1030; n++) begin
         if (n == 500) drain_distances();
         mode = $urandom_range(9);
         p.lat1 = random_lat();
         p.lon1 = random_lon();
         if (mode < 3) begin
            // Nearby points: small offsets from the station.
            p.lat2 = p.lat1 + longint'($urandom_range(20000, 0)) - 10000;
            p.lon2 = p.lon1 + longint'($urandom_range(20000, 0)) - 10000;
         end else if (mode == 3) begin
            // Close to the antipode.
            p.lat2 = -p.lat1 + longint'($urandom_range(2000, 0)) - 1000;
            p.lon2 = p.lon1 + 1800000000 + longint'($urandom_range(2000, 0)) - 1000;
         end else begin
            p.lat2 = random_lat();
            p.lon2 = random_lon();
         end
         p.lat2 = longint'($signed(p.lat2[LatW-1:0]));
         p.lon2 = longint'($signed(p.lon2[LonW-1:0]));
         send_pair(p);
      end

      drain_distances();
      repeat (130) @(posedge clock);
      if (error_count == 0) begin
         $display("** great_circle_distance_core: PASSED **");
      end else begin
         $display("** great_circle_distance_core: FAILED **");
      end
      $finish;
   end

   // Watchdog for a hung pipeline.
   initial begin
      #5000000;
      $display("** great_circle_distance_core: FAILED **");
      $finish;
   end

endmodule
